// File: design/scp_pkg.sv
`timescale 1ns / 1ps
package scp_pkg;

  typedef logic signed [23:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  localparam logic [1:0] OP_VTX_A = 2'd0;
  localparam logic [1:0] OP_VTX_B = 2'd1;
  localparam logic [1:0] OP_CTR_A = 2'd2;
  localparam logic [1:0] OP_START = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam coord_t PUSH_MAX = 24'sh7fffff;
  localparam coord_t PUSH_MIN = -24'sh800000;

endpackage

// File: design/sat_convex_polygon_collision_top.sv
`timescale 1ns / 1ps
// channel  ports                                         transfer
// input    start, busy, in_op, in_coord_x, in_coord_y    start high and busy low at clk
// result   out_valid, out_colliding, out_push_x/y,       out_valid high for one cycle
//          out_status
// vertex and center items are stored in the idle state, busy stays low
// a start item with fewer than two vertices in a polygon answers in the following cycle
// otherwise each axis reads an edge, forms its normal and, unless the edge has zero length,
// runs a shift-by-two normalize loop, a 32-step square root and two divides, then
// one vertex memory read plus two multiplies per vertex; states FX to DONE finish
// reset is synchronous and clears counts, flags and the sequencer
// the receiver cannot stall: the result is shown once, busy drops with it
module sat_convex_polygon_collision_top
  import scp_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [23:0] in_coord_x,
  input  logic signed [23:0] in_coord_y,
  output logic               out_valid,
  output logic               out_colliding,
  output logic signed [23:0] out_push_x,
  output logic signed [23:0] out_push_y,
  output logic [1:0]         out_status
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_E0   = 5'd1;
  localparam logic [4:0] S_E1   = 5'd2;
  localparam logic [4:0] S_E2   = 5'd3;
  localparam logic [4:0] S_SQX  = 5'd4;
  localparam logic [4:0] S_SQY  = 5'd5;
  localparam logic [4:0] S_SUM  = 5'd6;
  localparam logic [4:0] S_NORM = 5'd7;
  localparam logic [4:0] S_SQRT = 5'd8;
  localparam logic [4:0] S_DIV  = 5'd9;
  localparam logic [4:0] S_PRD  = 5'd10;
  localparam logic [4:0] S_PMX  = 5'd11;
  localparam logic [4:0] S_PMY  = 5'd12;
  localparam logic [4:0] S_PACC = 5'd13;
  localparam logic [4:0] S_DIST = 5'd14;
  localparam logic [4:0] S_FX   = 5'd15;
  localparam logic [4:0] S_FY   = 5'd16;
  localparam logic [4:0] S_FLIP = 5'd17;
  localparam logic [4:0] S_MX   = 5'd18;
  localparam logic [4:0] S_MY   = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  point_t mem_a [MAX_VERTICES];
  point_t mem_b [MAX_VERTICES];
  point_t rd_a_r, rd_b_r;
  logic [AW-1:0] rd_addr;

  logic [4:0]    state_r;
  logic [CW-1:0] cnt_a_r, cnt_b_r, n_a_r, n_b_r;
  logic          ovf_r;
  point_t        ctr_a_r, ctr_b_r;
  logic [1:0]    stat_r;

  logic          ap_r, pp_r, comp_r, have_r;
  logic [CW-1:0] k_r, j_r;
  point_t        p0_r;
  logic signed [24:0] nx_r, ny_r;
  logic [48:0]   sq_r, sq2_r;
  logic [61:0]   nsq_r, sn_r;
  logic [4:0]    s_r;
  logic [62:0]   res_r, bit_r;
  logic [5:0]    it_r;
  logic [30:0]   r_r, rem_r;
  logic [47:0]   num_r;
  logic [16:0]   q_r;
  logic signed [17:0] ax_r, ay_r, bx_r, by_r;
  logic signed [41:0] px_r, py_r;
  logic signed [42:0] lo_r, hi_r, loa_r, hia_r;
  logic [43:0]   best_r;
  logic signed [42:0] fx_r, fy_r;
  logic signed [62:0] prod_r;

  logic          out_valid_r, out_coll_r;
  coord_t        out_px_r, out_py_r;
  logic [1:0]    out_stat_r;

  logic          acc;
  point_t        cin, vdata;
  logic [CW-1:0] n_ax, k2;
  logic signed [42:0] dsum, lo_n, hi_n;
  logic signed [43:0] gap;
  logic [43:0]   mag;
  logic [62:0]   sq_tmp;
  logic [31:0]   dv_t;
  logic          q_bit;
  logic [16:0]   q_nxt;
  logic [23:0]   absc;
  logic [63:0]   sh;
  logic signed [17:0] axis_v;
  logic          comp_neg;
  logic signed [24:0] dx, dy;
  logic signed [41:0] mprod;
  logic signed [49:0] sqp;

  function automatic coord_t rnd_push(input logic signed [62:0] p);
    logic [62:0] m;
    logic [31:0] q;
    m = p[62] ? 63'(-p) : 63'(p);
    q = 32'((64'(m) + 64'h8000_0000) >> 32);
    if (p[62]) begin
      rnd_push = (q > 32'd8388608) ? PUSH_MIN : coord_t'(-q);
    end else begin
      rnd_push = (q > 32'd8388607) ? PUSH_MAX : coord_t'(q);
    end
  endfunction

  assign acc   = start && !busy;
  assign busy  = (state_r != S_IDLE);
  assign cin.x = in_coord_x;
  assign cin.y = in_coord_y;

  assign n_ax = ap_r ? n_b_r : n_a_r;
  assign k2   = (k_r + CW'(1) == n_ax) ? '0 : k_r + CW'(1);

  always_comb begin
    case (state_r)
      S_E0:    rd_addr = k_r[AW-1:0];
      S_E1:    rd_addr = k2[AW-1:0];
      default: rd_addr = j_r[AW-1:0];
    endcase
  end

  always_comb begin
    if (state_r inside {S_E1, S_E2}) begin
      vdata = ap_r ? rd_b_r : rd_a_r;
    end else begin
      vdata = pp_r ? rd_b_r : rd_a_r;
    end
  end

  assign dsum = 43'(px_r) + 43'(py_r);
  assign lo_n = (j_r == '0 || dsum < lo_r) ? dsum : lo_r;
  assign hi_n = (j_r == '0 || dsum > hi_r) ? dsum : hi_r;
  assign gap  = (loa_r < lo_r) ? 44'(lo_r) - 44'(hia_r) : 44'(loa_r) - 44'(hi_r);
  assign mag  = 44'(-gap);

  assign sq_tmp   = res_r + bit_r;
  assign dv_t     = {1'b0, rem_r} << 1 | 32'(num_r[47]);
  assign q_bit    = (dv_t >= {1'b0, r_r});
  assign q_nxt    = {q_r[15:0], q_bit};
  assign comp_neg = comp_r ? ny_r[24] : nx_r[24];
  assign absc     = comp_r ? (ny_r[24] ? 24'(-ny_r) : 24'(ny_r))
                           : (nx_r[24] ? 24'(-nx_r) : 24'(nx_r));
  assign sh       = 64'(absc) << s_r;
  assign axis_v   = comp_neg ? -$signed({1'b0, q_nxt}) : $signed({1'b0, q_nxt});
  assign dx       = 25'(ctr_a_r.x) - 25'(ctr_b_r.x);
  assign dy       = 25'(ctr_a_r.y) - 25'(ctr_b_r.y);
  assign mprod    = (state_r == S_PMX) ? ax_r * vdata.x : ay_r * vdata.y;
  assign sqp      = (state_r == S_SQX) ? nx_r * nx_r : ny_r * ny_r;

  // vertex memories
  always_ff @(posedge clk) begin
    if (acc && in_op == OP_VTX_A && cnt_a_r < CW'(MAX_VERTICES)) begin
      mem_a[cnt_a_r[AW-1:0]] <= cin;
    end
    if (acc && in_op == OP_VTX_B && cnt_b_r < CW'(MAX_VERTICES)) begin
      mem_b[cnt_b_r[AW-1:0]] <= cin;
    end
    rd_a_r <= mem_a[rd_addr];
    rd_b_r <= mem_b[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      ctr_a_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            case (in_op)
              OP_VTX_A: begin
                if (cnt_a_r < CW'(MAX_VERTICES)) cnt_a_r <= cnt_a_r + CW'(1);
                else ovf_r <= 1'b1;
              end
              OP_VTX_B: begin
                if (cnt_b_r < CW'(MAX_VERTICES)) cnt_b_r <= cnt_b_r + CW'(1);
                else ovf_r <= 1'b1;
              end
              OP_CTR_A: ctr_a_r <= cin;
              default: begin
                ctr_b_r <= cin;
                n_a_r   <= cnt_a_r;
                n_b_r   <= cnt_b_r;
                stat_r  <= ovf_r ? ST_OVF : ST_OK;
                cnt_a_r <= '0;
                cnt_b_r <= '0;
                ovf_r   <= 1'b0;
                if (cnt_a_r < CW'(2) || cnt_b_r < CW'(2)) begin
                  out_valid_r <= 1'b1;
                  out_coll_r  <= 1'b0;
                  out_px_r    <= '0;
                  out_py_r    <= '0;
                  out_stat_r  <= ST_FEW;
                end else begin
                  ap_r    <= 1'b0;
                  k_r     <= '0;
                  have_r  <= 1'b0;
                  state_r <= S_E0;
                end
              end
            endcase
          end
        end
        S_E0: state_r <= S_E1;
        S_E1: begin
          p0_r    <= vdata;
          state_r <= S_E2;
        end
        S_E2: begin
          nx_r    <= 25'(p0_r.y) - 25'(vdata.y);
          ny_r    <= 25'(vdata.x) - 25'(p0_r.x);
          state_r <= S_SQX;
        end
        S_SQX: begin
          sq_r    <= 49'(sqp);
          state_r <= S_SQY;
        end
        S_SQY: begin
          sq2_r   <= 49'(sqp);
          state_r <= S_SUM;
        end
        S_SUM: begin
          nsq_r <= 62'(sq_r) + 62'(sq2_r);
          s_r   <= '0;
          if (sq_r == '0 && sq2_r == '0) begin
            ax_r    <= '0;
            ay_r    <= '0;
            pp_r    <= 1'b0;
            j_r     <= '0;
            state_r <= S_PRD;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (s_r < 5'd30 && nsq_r[61:60] == 2'b00) begin
            nsq_r <= nsq_r << 2;
            s_r   <= s_r + 5'd1;
          end else begin
            sn_r    <= nsq_r;
            res_r   <= '0;
            bit_r   <= 63'(1) << 62;
            it_r    <= 6'd31;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (63'(sn_r) >= sq_tmp) begin
            sn_r  <= 62'(63'(sn_r) - sq_tmp);
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (it_r == '0) begin
            comp_r  <= 1'b0;
            state_r <= S_DIV;
            it_r    <= 6'd48;
          end else begin
            it_r <= it_r - 6'd1;
          end
        end
        S_DIV: begin
          if (it_r == 6'd48) begin
            r_r   <= res_r[30:0];
            num_r <= 48'((sh << 16) + 64'(res_r[30:1]));
            rem_r <= '0;
            q_r   <= '0;
            it_r  <= 6'd47;
          end else begin
            if (q_bit) begin
              rem_r <= 31'(dv_t - {1'b0, r_r});
            end else begin
              rem_r <= dv_t[30:0];
            end
            q_r   <= q_nxt;
            num_r <= num_r << 1;
            if (it_r == '0) begin
              it_r <= 6'd48;
              if (!comp_r) begin
                ax_r   <= axis_v;
                comp_r <= 1'b1;
              end else begin
                ay_r    <= axis_v;
                pp_r    <= 1'b0;
                j_r     <= '0;
                state_r <= S_PRD;
              end
            end else begin
              it_r <= it_r - 6'd1;
            end
          end
        end
        S_PRD: state_r <= S_PMX;
        S_PMX: begin
          px_r    <= mprod;
          state_r <= S_PMY;
        end
        S_PMY: begin
          py_r    <= mprod;
          state_r <= S_PACC;
        end
        S_PACC: begin
          lo_r <= lo_n;
          hi_r <= hi_n;
          if (j_r + CW'(1) == (pp_r ? n_b_r : n_a_r)) begin
            if (!pp_r) begin
              loa_r   <= lo_n;
              hia_r   <= hi_n;
              pp_r    <= 1'b1;
              j_r     <= '0;
              state_r <= S_PRD;
            end else begin
              state_r <= S_DIST;
            end
          end else begin
            j_r     <= j_r + CW'(1);
            state_r <= S_PRD;
          end
        end
        S_DIST: begin
          if (gap > 44'sd0) begin
            out_valid_r <= 1'b1;
            out_coll_r  <= 1'b0;
            out_px_r    <= '0;
            out_py_r    <= '0;
            out_stat_r  <= stat_r;
            state_r     <= S_IDLE;
          end else begin
            if (!have_r || mag < best_r) begin
              have_r <= 1'b1;
              best_r <= mag;
              bx_r   <= ax_r;
              by_r   <= ay_r;
            end
            if (k_r + CW'(1) == n_ax) begin
              k_r <= '0;
              if (!ap_r) begin
                ap_r    <= 1'b1;
                state_r <= S_E0;
              end else begin
                state_r <= S_FX;
              end
            end else begin
              k_r     <= k_r + CW'(1);
              state_r <= S_E0;
            end
          end
        end
        S_FX: begin
          fx_r    <= dx * bx_r;
          state_r <= S_FY;
        end
        S_FY: begin
          fy_r    <= dy * by_r;
          state_r <= S_FLIP;
        end
        S_FLIP: begin
          if (44'(fx_r) + 44'(fy_r) < 44'sd0) begin
            bx_r <= -bx_r;
            by_r <= -by_r;
          end
          state_r <= S_MX;
        end
        S_MX: begin
          prod_r  <= $signed({1'b0, best_r}) * bx_r;
          state_r <= S_MY;
        end
        S_MY: begin
          out_px_r <= rnd_push(prod_r);
          prod_r   <= $signed({1'b0, best_r}) * by_r;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_coll_r  <= 1'b1;
          out_py_r    <= rnd_push(prod_r);
          out_stat_r  <= stat_r;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_colliding = out_coll_r;
  assign out_push_x    = out_px_r;
  assign out_push_y    = out_py_r;
  assign out_status    = out_stat_r;

`ifndef ASSERT_OFF
  a_sep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_colliding |-> out_push_x == '0 && out_push_y == '0)
    else $error("push not zero without collision");

  a_few_nocoll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FEW |-> !out_colliding)
    else $error("collision reported with too few vertices");

  a_start_acts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_START |=> busy || out_valid)
    else $error("start transfer ignored");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_op == OP_START))
    else $error("busy without start");
`endif

endmodule

// File: verif/sat_convex_polygon_collision_top_test.sv
`timescale 1ns / 1ps
module sat_convex_polygon_collision_top_test;
  import scp_pkg::*;

  localparam int MAXV = 16;
  localparam int QUIET_LIMIT = 60000;
  localparam int ITEM_GOAL = 1650;
  localparam real TWO_PI = 6.283185307179586;

  typedef struct {
    longint x;
    longint y;
  } pt_t;

  typedef struct {
    logic       colliding;
    coord_t     push_x;
    coord_t     push_y;
    logic [1:0] status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = OP_VTX_A;
  logic signed [23:0] in_coord_x = '0;
  logic signed [23:0] in_coord_y = '0;
  logic out_valid;
  logic out_colliding;
  logic signed [23:0] out_push_x;
  logic signed [23:0] out_push_y;
  logic [1:0] out_status;

  sat_convex_polygon_collision_top #(.MAX_VERTICES(MAXV)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_colliding(out_colliding),
    .out_push_x(out_push_x), .out_push_y(out_push_y), .out_status(out_status)
  );

  always #4 clk = ~clk;

  // shadow state of the collision engine
  pt_t poly_a [MAXV];
  pt_t poly_b [MAXV];
  int unsigned cnt_a = 0;
  int unsigned cnt_b = 0;
  pt_t ctr_a = '{0, 0};
  bit ovf_flag = 0;

  verdict_t pending_verdicts[$];
  int errors = 0;
  int items_sent = 0;
  int n_tests = 0, n_hits = 0, n_apart = 0, n_few = 0, n_ovf = 0;
  bit idle_on = 1;
  int quiet = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint c, int s, longint unsigned r);
    longint unsigned m, q;
    m = (c < 0) ? longint'(-c) : longint'(c);
    q = (((m << s) << 16) + (r >> 1)) / r;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic unit_axis(input longint ex, input longint ey,
                           output longint ax, output longint ay);
    longint unsigned n2, r;
    int s;
    n2 = longint'(ex * ex) + longint'(ey * ey);
    s = 0;
    if (n2 == 0) begin
      ax = 0;
      ay = 0;
    end else begin
      while (s < 30 && n2 < (64'h4000_0000_0000_0000 >> (2 * s + 2))) s++;
      r = int_sqrt(n2 << (2 * s));
      ax = unit_part(ex, s, r);
      ay = unit_part(ey, s, r);
    end
  endtask

  task automatic span_of(input longint ax, input longint ay, input bit use_a,
                         input int unsigned n, output longint lo, output longint hi);
    longint d;
    pt_t p;
    for (int k = 0; k < n; k++) begin
      p = use_a ? poly_a[k] : poly_b[k];
      d = ax * p.x + ay * p.y;
      if (k == 0 || d < lo) lo = d;
      if (k == 0 || d > hi) hi = d;
    end
  endtask

  function automatic coord_t scaled_push(longint ov, longint a);
    longint prod, q;
    longint unsigned m;
    prod = ov * a;
    m = (prod < 0) ? longint'(-prod) : longint'(prod);
    q = longint'((m + 64'h8000_0000) >> 32);
    if (prod < 0) q = -q;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return coord_t'(q);
  endfunction

  task automatic run_sat(input pt_t ctr_b);
    verdict_t v;
    int unsigned n1, n2, n, k, k2;
    bit have, use_a, apart;
    longint best, bx, by, ax, ay, loa, hia, lob, hib, gap, ex, ey;
    pt_t p0, p1;
    n1 = cnt_a;
    n2 = cnt_b;
    v = '{1'b0, '0, '0, ovf_flag ? ST_OVF : ST_OK};
    cnt_a = 0;
    cnt_b = 0;
    ovf_flag = 0;
    have = 0;
    apart = 0;
    best = 0;
    bx = 0;
    by = 0;
    n_tests++;
    if (n1 < 2 || n2 < 2) begin
      v.status = ST_FEW;
      n_few++;
    end else begin
      if (v.status == ST_OVF) n_ovf++;
      for (int i = 0; i < n1 + n2 && !apart; i++) begin
        use_a = (i < n1);
        n = use_a ? n1 : n2;
        k = use_a ? i : i - n1;
        k2 = (k + 1 == n) ? 0 : k + 1;
        p0 = use_a ? poly_a[k] : poly_b[k];
        p1 = use_a ? poly_a[k2] : poly_b[k2];
        ex = -(p1.y - p0.y);
        ey = p1.x - p0.x;
        unit_axis(ex, ey, ax, ay);
        span_of(ax, ay, 1, n1, loa, hia);
        span_of(ax, ay, 0, n2, lob, hib);
        gap = (loa < lob) ? lob - hia : loa - hib;
        if (gap > 0) begin
          apart = 1;
        end else begin
          gap = -gap;
          if (!have || gap < best) begin
            have = 1;
            best = gap;
            bx = ax;
            by = ay;
            if ((ctr_a.x - ctr_b.x) * bx + (ctr_a.y - ctr_b.y) * by < 0) begin
              bx = -bx;
              by = -by;
            end
          end
        end
      end
      if (apart) begin
        n_apart++;
      end else begin
        n_hits++;
        v.colliding = 1'b1;
        v.push_x = scaled_push(best, bx);
        v.push_y = scaled_push(best, by);
      end
    end
    pending_verdicts.push_back(v);
  endtask

  task automatic apply_item(input logic [1:0] op, input pt_t c);
    case (op)
      OP_VTX_A: begin
        if (cnt_a < MAXV) poly_a[cnt_a++] = c;
        else ovf_flag = 1;
      end
      OP_VTX_B: begin
        if (cnt_b < MAXV) poly_b[cnt_b++] = c;
        else ovf_flag = 1;
      end
      OP_CTR_A: ctr_a = c;
      default: run_sat(c);
    endcase
  endtask

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // called at a falling edge; returns at a falling edge with start still high
  task automatic send_item(input logic [1:0] op, input longint x, input longint y);
    pt_t c;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    c.x = clamp24(x);
    c.y = clamp24(y);
    start = 1'b1;
    in_op = op;
    in_coord_x = coord_t'(c.x);
    in_coord_y = coord_t'(c.y);
    do @(posedge clk); while (busy);
    c.x = in_coord_x;
    c.y = in_coord_y;
    apply_item(op, c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch on %s: got %0d expected %0d (test %0d)", what, got, want, n_tests);
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("result transfer with nothing expected");
      end else begin
        v = pending_verdicts.pop_front();
        if (out_colliding !== v.colliding) report_mismatch("colliding", out_colliding, v.colliding);
        if (out_push_x !== v.push_x) report_mismatch("push_x", out_push_x, v.push_x);
        if (out_push_y !== v.push_y) report_mismatch("push_y", out_push_y, v.push_y);
        if (out_status !== v.status) report_mismatch("status", out_status, v.status);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > QUIET_LIMIT) begin
      $display("sat_convex_polygon_collision_top_test failed");
      $finish;
    end
  end

  // roughly regular convex polygon around a center
  task automatic load_polygon(input logic [1:0] op, input longint cx, input longint cy,
                              input longint rad, input int n);
    real phase, a;
    phase = $urandom_range(0, 999) * TWO_PI / 1000.0;
    for (int k = 0; k < n; k++) begin
      a = phase + TWO_PI * k / n;
      send_item(op, cx + $rtoi(rad * $cos(a)), cy + $rtoi(rad * $sin(a)));
    end
  endtask

  task automatic test_few_vertices();
    send_item(OP_START, 0, 0);
    send_item(OP_VTX_A, 100, -100);
    send_item(OP_VTX_B, 5, 5);
    send_item(OP_VTX_B, -5, 7);
    send_item(OP_START, 1, 1);
    wait_drained();
  endtask

  // full corners, repeated corners and one vertex past capacity
  task automatic test_overflow_extremes();
    for (int k = 0; k < MAXV + 1; k++)
      send_item(OP_VTX_A, (k % 4 == 1 || k % 4 == 2) ? 8388607 : -8388608,
                (k % 4 >= 2) ? 8388607 : -8388608);
    send_item(OP_VTX_B, 8388607, -8388608);
    send_item(OP_START, -8388608, 8388607);
    wait_drained();
  endtask

  task automatic random_sequence();
    int n1, n2, sh;
    longint cx, cy, rad, rad2, ox, oy;
    if ($urandom_range(0, 9) == 0) begin
      // noise: arbitrary ops and full-range coordinates
      repeat ($urandom_range(1, 20))
        send_item(2'($urandom_range(0, 2)), longint'($signed(24'($urandom))),
                  longint'($signed(24'($urandom))));
      send_item(OP_START, longint'($signed(24'($urandom))), longint'($signed(24'($urandom))));
      return;
    end
    n1 = ($urandom_range(0, 19) == 0) ? MAXV : $urandom_range(3, 5);
    n2 = ($urandom_range(0, 19) == 0) ? MAXV : $urandom_range(3, 5);
    sh = $urandom_range(4, 22);
    rad = $urandom_range(1 << (sh - 1), 1 << sh);
    rad2 = $urandom_range(1 << (sh - 1), 1 << sh);
    cx = longint'($signed(24'($urandom))) >>> $urandom_range(0, 8);
    cy = longint'($signed(24'($urandom))) >>> $urandom_range(0, 8);
    ox = cx + (longint'($urandom_range(0, 2000)) - 1000) * (rad + rad2) / 700;
    oy = cy + (longint'($urandom_range(0, 2000)) - 1000) * (rad + rad2) / 700;
    if ($urandom_range(0, 1)) send_item(OP_CTR_A, cx, cy);
    load_polygon(OP_VTX_A, cx, cy, rad, n1);
    load_polygon(OP_VTX_B, ox, oy, rad2, n2);
    if ($urandom_range(0, 3) != 0) send_item(OP_CTR_A, cx, cy);
    send_item(OP_START, ox, oy);
  endtask

  task automatic test_random();
    while (items_sent < ITEM_GOAL) begin
      if (items_sent > ITEM_GOAL - 200) idle_on = 0;
      random_sequence();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_few_vertices();
    test_overflow_extremes();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk);
    $display("%0d items, %0d collision tests: %0d hits, %0d apart", items_sent, n_tests,
             n_hits, n_apart);
    $display("%0d with too few vertices, %0d with dropped vertices", n_few, n_ovf);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("sat_convex_polygon_collision_top_test passed");
    end else begin
      $display("sat_convex_polygon_collision_top_test failed");
    end
    $finish;
  end

endmodule
